// File: rtl/mle_pkg.sv
// Shared constants, types and a helper function for the Maidenhead locator encoder.
`timescale 1ns / 1ps
package mle_pkg;

    // Pre-scaled offset word that enters the fine-cell divider, below 675000000.
    typedef logic [29:0] t_fine_x;
    // Finest cell index, below 43200.
    typedef logic [15:0] t_fine_idx;
    // Level count register.
    typedef logic [2:0]  t_levels;

    // Half spans in 1e-7 degree units.
    localparam logic signed [32:0] LON_HALF     = 33'sd1800000000;
    localparam logic [31:0]        LON_TOP_OFF  = 32'd3599999999;
    localparam logic signed [31:0] LAT_HALF     = 32'sd900000000;
    localparam logic [30:0]        LAT_TOP_OFF  = 31'd1799999999;

    // The fine index is floor(3 * off / 250000) for longitude and floor(3 * off / 125000)
    // for latitude; after a shift by four or three both become a division by 15625.
    localparam logic [29:0] FINE_DIVISOR    = 30'd15625;
    localparam logic [30:0] FINE_RECIP      = 31'd1125899906;
    localparam int          FINE_RECIP_SH   = 44;

    // Reciprocals for the mixed-radix digit split.
    localparam logic [15:0] RECIP_DIV10_WIDE = 16'd52429;
    localparam logic [9:0]  RECIP_DIV3       = 10'd683;
    localparam logic [7:0]  RECIP_DIV10_NAR  = 8'd205;

    // Character bases.
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;
    localparam logic [6:0] CHAR_LOWER_A = 7'd97;
    localparam logic [5:0] CHAR_ZERO    = 6'd48;

    // Largest useful level count.
    localparam t_levels MAX_LEVELS   = 3'd4;
    localparam t_levels RESET_LEVELS = 3'd3;

    // Pipeline depth from acceptance to the output register.
    localparam int PIPE_DEPTH = 7;

    // Multiply by ten using shifts and an add.
    function automatic logic [16:0] times_ten(input logic [13:0] v);
        times_ten = {v, 3'b000} + {2'b00, v, 1'b0};
    endfunction

endpackage

// File: rtl/maidenhead_locator_encoder.sv
// A word accepted on start passes the offset, divider, digit-split and output registers and then appears with o_strobe.
// Throughput: one word per cycle; a seven-stage pipeline with no feedback sets the rate.
// busy is never raised and the receiver cannot stall, so nothing is ever held back.
// Reset (synchronous, active low) clears the valid pipeline and sets the level count to three.
`timescale 1ns / 1ps
module maidenhead_locator_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_longitude,
    input  logic [30:0] i_latitude,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [6:0]  o_field_lon_char,
    output logic [6:0]  o_field_lat_char,
    output logic [5:0]  o_square_lon_char,
    output logic [5:0]  o_square_lat_char,
    output logic [6:0]  o_subsquare_lon_char,
    output logic [6:0]  o_subsquare_lat_char,
    output logic [5:0]  o_extended_lon_char,
    output logic [5:0]  o_extended_lat_char,
    output logic [3:0]  o_chars_written
);
    import mle_pkg::*;

    t_fine_x   lon_x;
    t_fine_x   lat_x;
    t_fine_idx lon_idx;
    t_fine_idx lat_idx;
    logic [4:0] lon_field, lat_field, lon_sub, lat_sub;
    logic [3:0] lon_sq, lat_sq, lon_ext, lat_ext;

    t_levels                 r_levels;
    t_levels                 lv;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic [PIPE_DEPTH-1:0]   n_vld;

    logic [6:0] n_field_lon, n_field_lat, n_sub_lon, n_sub_lat;
    logic [5:0] n_sq_lon, n_sq_lat, n_ext_lon, n_ext_lat;
    logic [3:0] n_chars;
    logic [6:0] r_field_lon, r_field_lat, r_sub_lon, r_sub_lat;
    logic [5:0] r_sq_lon, r_sq_lat, r_ext_lon, r_ext_lat;
    logic [3:0] r_chars;

    assign busy = 1'b0;

    // Level count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= RESET_LEVELS;
        end else if (i_cfg_we) begin
            r_levels <= i_cfg_wdata;
        end
    end

    // Valid bits travel alongside the data stages.
    assign n_vld = {r_vld[PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    mle_offset u_offset (
        .i_clk       (i_clk),
        .i_longitude (i_longitude),
        .i_latitude  (i_latitude),
        .o_lon_x     (lon_x),
        .o_lat_x     (lat_x)
    );

    mle_fine_div u_lon_div (
        .i_clk (i_clk),
        .i_x   (lon_x),
        .o_idx (lon_idx)
    );

    mle_fine_div u_lat_div (
        .i_clk (i_clk),
        .i_x   (lat_x),
        .o_idx (lat_idx)
    );

    mle_digit_split u_lon_split (
        .i_clk       (i_clk),
        .i_idx       (lon_idx),
        .o_field     (lon_field),
        .o_square    (lon_sq),
        .o_subsquare (lon_sub),
        .o_extended  (lon_ext)
    );

    mle_digit_split u_lat_split (
        .i_clk       (i_clk),
        .i_idx       (lat_idx),
        .o_field     (lat_field),
        .o_square    (lat_sq),
        .o_subsquare (lat_sub),
        .o_extended  (lat_ext)
    );

    // Character formatting, with levels beyond the count forced to zero.
    always_comb begin
        lv          = (r_levels > MAX_LEVELS) ? MAX_LEVELS : r_levels;
        n_field_lon = (lv > 3'd0) ? CHAR_UPPER_A + {2'b00, lon_field} : 7'd0;
        n_field_lat = (lv > 3'd0) ? CHAR_UPPER_A + {2'b00, lat_field} : 7'd0;
        n_sq_lon    = (lv > 3'd1) ? CHAR_ZERO + {2'b00, lon_sq} : 6'd0;
        n_sq_lat    = (lv > 3'd1) ? CHAR_ZERO + {2'b00, lat_sq} : 6'd0;
        n_sub_lon   = (lv > 3'd2) ? CHAR_LOWER_A + {2'b00, lon_sub} : 7'd0;
        n_sub_lat   = (lv > 3'd2) ? CHAR_LOWER_A + {2'b00, lat_sub} : 7'd0;
        n_ext_lon   = (lv > 3'd3) ? CHAR_ZERO + {2'b00, lon_ext} : 6'd0;
        n_ext_lat   = (lv > 3'd3) ? CHAR_ZERO + {2'b00, lat_ext} : 6'd0;
        n_chars     = {lv, 1'b0};
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_field_lon <= n_field_lon;
        r_field_lat <= n_field_lat;
        r_sq_lon    <= n_sq_lon;
        r_sq_lat    <= n_sq_lat;
        r_sub_lon   <= n_sub_lon;
        r_sub_lat   <= n_sub_lat;
        r_ext_lon   <= n_ext_lon;
        r_ext_lat   <= n_ext_lat;
        r_chars     <= n_chars;
    end

    assign o_strobe             = r_vld[PIPE_DEPTH-1];
    assign o_field_lon_char     = r_field_lon;
    assign o_field_lat_char     = r_field_lat;
    assign o_square_lon_char    = r_sq_lon;
    assign o_square_lat_char    = r_sq_lat;
    assign o_subsquare_lon_char = r_sub_lon;
    assign o_subsquare_lat_char = r_sub_lat;
    assign o_extended_lon_char  = r_ext_lon;
    assign o_extended_lat_char  = r_ext_lat;
    assign o_chars_written      = r_chars;

endmodule

// File: rtl/mle_offset.sv
// First stage: saturation, offset to the positive range and pre-scaling of both coordinates.
`timescale 1ns / 1ps
module mle_offset (
    input  logic              i_clk,
    input  logic [31:0]       i_longitude,
    input  logic [30:0]       i_latitude,
    output mle_pkg::t_fine_x  o_lon_x,
    output mle_pkg::t_fine_x  o_lat_x
);
    import mle_pkg::*;

    logic signed [32:0] lon_ext;
    logic signed [32:0] lon_sum;
    logic [31:0]        lon_off;
    logic [33:0]        lon_x3;
    logic signed [31:0] lat_ext;
    logic signed [31:0] lat_sum;
    logic [30:0]        lat_off;
    logic [32:0]        lat_x3;
    t_fine_x            n_lon_x;
    t_fine_x            n_lat_x;
    t_fine_x            r_lon_x;
    t_fine_x            r_lat_x;

    // Longitude: clamp to the span, pulling the exact east edge into the last cell.
    always_comb begin
        lon_ext = {i_longitude[31], i_longitude};
        lon_sum = lon_ext + LON_HALF;
        if (lon_ext >= LON_HALF) begin
            lon_off = LON_TOP_OFF;
        end else if (lon_ext < -LON_HALF) begin
            lon_off = 32'd0;
        end else begin
            lon_off = lon_sum[31:0];
        end
        lon_x3  = {2'b00, lon_off} + {1'b0, lon_off, 1'b0};
        n_lon_x = lon_x3[33:4];
    end

    // Latitude: the same with half the span, so one bit less of shift.
    always_comb begin
        lat_ext = {i_latitude[30], i_latitude};
        lat_sum = lat_ext + LAT_HALF;
        if (lat_ext >= LAT_HALF) begin
            lat_off = LAT_TOP_OFF;
        end else if (lat_ext < -LAT_HALF) begin
            lat_off = 31'd0;
        end else begin
            lat_off = lat_sum[30:0];
        end
        lat_x3  = {2'b00, lat_off} + {1'b0, lat_off, 1'b0};
        n_lat_x = lat_x3[32:3];
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        r_lon_x <= n_lon_x;
        r_lat_x <= n_lat_x;
    end

    assign o_lon_x = r_lon_x;
    assign o_lat_x = r_lat_x;

endmodule

// File: rtl/mle_fine_div.sv
// Two-stage division by 15625 through a reciprocal multiply and a one-step correction.
`timescale 1ns / 1ps
module mle_fine_div (
    input  logic               i_clk,
    input  mle_pkg::t_fine_x   i_x,
    output mle_pkg::t_fine_idx o_idx
);
    import mle_pkg::*;

    logic [60:0] prod;
    logic [16:0] n_qe;
    logic [16:0] r_qe;
    t_fine_x     r_x;
    logic [30:0] qe_times_d;
    logic [30:0] rem;
    logic [16:0] q_fix;
    t_fine_idx   n_idx;
    t_fine_idx   r_idx;

    // Estimate: never above the true quotient and at most one below it.
    always_comb begin
        prod = {31'd0, i_x} * {30'd0, FINE_RECIP};
        n_qe = prod[60:FINE_RECIP_SH];
    end

    always_ff @(posedge i_clk) begin
        r_qe <= n_qe;
        r_x  <= i_x;
    end

    // Correction: bump the estimate when the remainder reaches the divisor.
    always_comb begin
        qe_times_d = {14'd0, r_qe} * {1'b0, FINE_DIVISOR};
        rem        = {1'b0, r_x} - qe_times_d;
        q_fix      = (rem >= {1'b0, FINE_DIVISOR}) ? r_qe + 17'd1 : r_qe;
        n_idx      = q_fix[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_idx = r_idx;

endmodule

// File: rtl/mle_digit_split.sv
// Three-stage mixed-radix split of a fine index into field, square, subsquare and extended digits.
`timescale 1ns / 1ps
module mle_digit_split (
    input  logic               i_clk,
    input  mle_pkg::t_fine_idx i_idx,
    output logic [4:0]         o_field,
    output logic [3:0]         o_square,
    output logic [4:0]         o_subsquare,
    output logic [3:0]         o_extended
);
    import mle_pkg::*;

    logic [31:0] p4;
    logic [12:0] n_t1;
    logic [16:0] t1_x10;
    logic [15:0] ext_diff;
    logic [12:0] r_t1;
    logic [3:0]  r_ext4;

    logic [19:0] p5;
    logic [7:0]  n_t2;
    logic [12:0] t2_x24;
    logic [12:0] sub_diff;
    logic [7:0]  r_t2;
    logic [4:0]  r_sub5;
    logic [3:0]  r_ext5;

    logic [15:0] p6;
    logic [4:0]  n_field;
    logic [16:0] field_x10;
    logic [7:0]  sq_diff;
    logic [4:0]  r_field;
    logic [3:0]  r_sq;
    logic [4:0]  r_sub6;
    logic [3:0]  r_ext6;

    // Extended digit: index modulo ten, quotient goes on.
    always_comb begin
        p4       = {16'd0, i_idx} * {16'd0, RECIP_DIV10_WIDE};
        n_t1     = p4[31:19];
        t1_x10   = times_ten({1'b0, n_t1});
        ext_diff = i_idx - t1_x10[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= n_t1;
        r_ext4 <= ext_diff[3:0];
    end

    // Subsquare: quotient modulo twenty-four, dividing by eight then by three.
    always_comb begin
        p5       = {10'd0, r_t1[12:3]} * {10'd0, RECIP_DIV3};
        n_t2     = p5[18:11];
        t2_x24   = {1'b0, n_t2, 4'b0000} + {2'b00, n_t2, 3'b000};
        sub_diff = r_t1 - t2_x24;
    end

    always_ff @(posedge i_clk) begin
        r_t2   <= n_t2;
        r_sub5 <= sub_diff[4:0];
        r_ext5 <= r_ext4;
    end

    // Square and field: the remaining quotient split by ten.
    always_comb begin
        p6        = {8'd0, r_t2} * {8'd0, RECIP_DIV10_NAR};
        n_field   = p6[15:11];
        field_x10 = times_ten({9'd0, n_field});
        sq_diff   = r_t2 - field_x10[7:0];
    end

    always_ff @(posedge i_clk) begin
        r_field <= n_field;
        r_sq    <= sq_diff[3:0];
        r_sub6  <= r_sub5;
        r_ext6  <= r_ext5;
    end

    assign o_field     = r_field;
    assign o_square    = r_sq;
    assign o_subsquare = r_sub6;
    assign o_extended  = r_ext6;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the Maidenhead locator encoder, with a locator scoreboard class.
`timescale 1ns / 1ps

// One locator as it leaves the encoder.
typedef struct packed {
    logic [6:0] field_lon;
    logic [6:0] field_lat;
    logic [5:0] square_lon;
    logic [5:0] square_lat;
    logic [6:0] subsquare_lon;
    logic [6:0] subsquare_lat;
    logic [5:0] extended_lon;
    logic [5:0] extended_lat;
    logic [3:0] chars_written;
} t_locator;

// Holds the expected locators in order and checks each one that the encoder delivers.
class locator_tracker;
    localparam longint LON_HALF_SPAN = 64'd1800000000;
    localparam longint LAT_HALF_SPAN = 64'd900000000;
    localparam longint FINE_CELLS    = 64'd43200;
    localparam int     LEVEL_CAP     = 4;
    localparam int     ASCII_UPPER_A = 65;
    localparam int     ASCII_LOWER_A = 97;
    localparam int     ASCII_ZERO    = 48;

    mle_pkg::t_levels levels;
    t_locator         pending_locators[$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
        levels     = mle_pkg::RESET_LEVELS;
        mismatches = 0;
        checked    = 0;
    endfunction

    function void set_levels(mle_pkg::t_levels value);
        levels = value;
    endfunction

    function int unsigned outstanding();
        return pending_locators.size();
    endfunction

    // Saturate to the span, offset to zero and pull the exact top edge into the last cell.
    function longint fine_cell(longint value, longint half);
        longint off;
        if (value < -half) begin
            value = -half;
        end
        if (value > half) begin
            value = half;
        end
        off = value + half;
        if (off >= 2 * half) begin
            off = 2 * half - 1;
        end
        return (off * FINE_CELLS) / (2 * half);
    endfunction

    // Mixed-radix split of both fine indexes into the character pairs in use.
    function t_locator encode_locator(logic [31:0] lon, logic [30:0] lat);
        t_locator r;
        longint   li;
        longint   ti;
        int       n;
        li = fine_cell(longint'($signed(lon)), LON_HALF_SPAN);
        ti = fine_cell(longint'($signed(lat)), LAT_HALF_SPAN);
        n  = (levels > LEVEL_CAP) ? LEVEL_CAP : int'(levels);
        r  = '0;
        if (n >= 1) begin
            r.field_lon = 7'(ASCII_UPPER_A + li / 2400);
            r.field_lat = 7'(ASCII_UPPER_A + ti / 2400);
        end
        if (n >= 2) begin
            r.square_lon = 6'(ASCII_ZERO + (li / 240) % 10);
            r.square_lat = 6'(ASCII_ZERO + (ti / 240) % 10);
        end
        if (n >= 3) begin
            r.subsquare_lon = 7'(ASCII_LOWER_A + (li / 10) % 24);
            r.subsquare_lat = 7'(ASCII_LOWER_A + (ti / 10) % 24);
        end
        if (n >= 4) begin
            r.extended_lon = 6'(ASCII_ZERO + li % 10);
            r.extended_lat = 6'(ASCII_ZERO + ti % 10);
        end
        r.chars_written = 4'(2 * n);
        return r;
    endfunction

    // Called for every accepted coordinate word.
    function void note_fix(logic [31:0] lon, logic [30:0] lat);
        pending_locators.push_back(encode_locator(lon, lat));
    endfunction

    function void compare_field(string name, logic [6:0] exp_val, logic [6:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    // Called for every strobed locator; compares it with the oldest expectation.
    function void check_locator(t_locator got);
        t_locator exp_loc;
        if (pending_locators.size() == 0) begin
            $error("locator: expected none, actual word with %0d characters",
                   got.chars_written);
            mismatches++;
            return;
        end
        exp_loc = pending_locators.pop_front();
        checked++;
        compare_field("field_lon_char", exp_loc.field_lon, got.field_lon);
        compare_field("field_lat_char", exp_loc.field_lat, got.field_lat);
        compare_field("square_lon_char", 7'(exp_loc.square_lon), 7'(got.square_lon));
        compare_field("square_lat_char", 7'(exp_loc.square_lat), 7'(got.square_lat));
        compare_field("subsquare_lon_char", exp_loc.subsquare_lon, got.subsquare_lon);
        compare_field("subsquare_lat_char", exp_loc.subsquare_lat, got.subsquare_lat);
        compare_field("extended_lon_char", 7'(exp_loc.extended_lon), 7'(got.extended_lon));
        compare_field("extended_lat_char", 7'(exp_loc.extended_lat), 7'(got.extended_lat));
        compare_field("chars_written", 7'(exp_loc.chars_written), 7'(got.chars_written));
    endfunction
endclass

module tb;
    localparam int PHASE_WORDS  = 128;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_NUM = 20;
    localparam int RESET_LEVEL_WORDS = 3;

    // Directed coordinates: span edges, exact top edges, saturation, cell boundaries.
    localparam int DIRECTED_LON[DIRECTED_NUM] = '{
        -1800000000, 1800000000, 0, -1, 1799999999, -1799999999,
        32'h80000000, 32'h7fffffff, 1800000001, -1800000001,
        -1799916666, -1799916667, 1, -1560000000, 1560000000,
        -1, 999999999, -1800000000, 1800000000, 123456789
    };
    localparam int DIRECTED_LAT[DIRECTED_NUM] = '{
        -900000000, 900000000, 0, -1, 899999999, -899999999,
        31'h40000000, 31'h3fffffff, 900000001, -900000001,
        -899958333, -899958334, 1, 900000000, -900000000,
        -899958334, -5, 900000000, -900000000, -987654321
    };

    // Level settings per random phase; the first and last extremes included.
    localparam mle_pkg::t_levels PHASE_LEVELS[9] = '{
        3'd4, 3'd0, 3'd1, 3'd2, 3'd7, 3'd5, 3'd6, 3'd3, 3'd4
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_longitude;
    logic [30:0] i_latitude;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        o_strobe;
    logic [6:0]  o_field_lon_char;
    logic [6:0]  o_field_lat_char;
    logic [5:0]  o_square_lon_char;
    logic [5:0]  o_square_lat_char;
    logic [6:0]  o_subsquare_lon_char;
    logic [6:0]  o_subsquare_lat_char;
    logic [5:0]  o_extended_lon_char;
    logic [5:0]  o_extended_lat_char;
    logic [3:0]  o_chars_written;

    locator_tracker book;
    int unsigned    words_sent = 0;
    int unsigned    cycle_count = 0;

    maidenhead_locator_encoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_longitude         (i_longitude),
        .i_latitude          (i_latitude),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_strobe            (o_strobe),
        .o_field_lon_char    (o_field_lon_char),
        .o_field_lat_char    (o_field_lat_char),
        .o_square_lon_char   (o_square_lon_char),
        .o_square_lat_char   (o_square_lat_char),
        .o_subsquare_lon_char(o_subsquare_lon_char),
        .o_subsquare_lat_char(o_subsquare_lat_char),
        .o_extended_lon_char (o_extended_lon_char),
        .o_extended_lat_char (o_extended_lat_char),
        .o_chars_written     (o_chars_written)
    );

    // Clock generation, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, well above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Every strobed locator word is checked; the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            book.check_locator('{o_field_lon_char, o_field_lat_char,
                                 o_square_lon_char, o_square_lat_char,
                                 o_subsquare_lon_char, o_subsquare_lat_char,
                                 o_extended_lon_char, o_extended_lat_char,
                                 o_chars_written});
        end
    end

    // Present one coordinate word and hold it until the encoder takes it.
    task automatic send_fix(logic [31:0] lon, logic [30:0] lat);
        start       <= 1'b1;
        i_longitude <= lon;
        i_latitude  <= lat;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        book.note_fix(lon, lat);
        words_sent++;
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait until every expected locator has come back.
    task automatic drain_locators();
        start <= 1'b0;
        while (book.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Level count write, issued only while the encoder is empty.
    task automatic write_levels(mle_pkg::t_levels value);
        drain_locators();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.set_levels(value);
    endtask

    // Longitude mix: mostly in range, some raw words, edges, cell boundaries and near zero.
    function automatic logic [31:0] pick_longitude();
        longint off;
        case ($urandom_range(0, 9))
            6: return $urandom();
            7: begin
                off = longint'($urandom_range(0, 40)) - 20;
                return ($urandom_range(0, 1) != 0) ? 32'(64'd1800000000 + off)
                                                   : 32'(-64'd1800000000 + off);
            end
            8: begin
                off = (longint'($urandom_range(0, 43200)) * 250000 + 2) / 3;
                off = off + longint'($urandom_range(0, 4)) - 2;
                return 32'(off - 64'd1800000000);
            end
            9: return 32'(longint'($urandom_range(0, 2000)) - 1000);
            default: return 32'($urandom_range(0, 32'd3600000000)) - 32'd1800000000;
        endcase
    endfunction

    // Latitude mix, same shape over its own span.
    function automatic logic [30:0] pick_latitude();
        longint off;
        case ($urandom_range(0, 9))
            6: return 31'($urandom());
            7: begin
                off = longint'($urandom_range(0, 40)) - 20;
                return ($urandom_range(0, 1) != 0) ? 31'(64'd900000000 + off)
                                                   : 31'(-64'd900000000 + off);
            end
            8: begin
                off = (longint'($urandom_range(0, 43200)) * 125000 + 2) / 3;
                off = off + longint'($urandom_range(0, 4)) - 2;
                return 31'(off - 64'd900000000);
            end
            9: return 31'(longint'($urandom_range(0, 2000)) - 1000);
            default: return 31'(longint'($urandom_range(0, 1800000000)) - 64'd900000000);
        endcase
    endfunction

    initial begin
        book = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_longitude <= '0;
        i_latitude  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few directed words at the reset level count, the rest with all four pairs.
        for (int d = 0; d < DIRECTED_NUM; d++) begin
            if (d == RESET_LEVEL_WORDS) begin
                write_levels(mle_pkg::MAX_LEVELS);
            end
            send_fix(32'(DIRECTED_LON[d]), 31'(DIRECTED_LAT[d]));
        end

        // Random phases, one level setting each; the last phase runs without gaps.
        for (int p = 0; p < $size(PHASE_LEVELS); p++) begin
            write_levels(PHASE_LEVELS[p]);
            for (int w = 0; w < PHASE_WORDS; w++) begin
                if (p == 3 && w == PHASE_WORDS / 2) begin
                    drain_locators();
                end
                if (p != $size(PHASE_LEVELS) - 1 && ((w / 32) % 3) != 2
                        && $urandom_range(0, 2) == 0) begin
                    hold_off($urandom_range(1, 13));
                end
                send_fix(pick_longitude(), pick_latitude());
            end
        end

        drain_locators();
        repeat (mle_pkg::PIPE_DEPTH + 3) @(posedge i_clk);

        $display("Summary: %0d coordinate words sent, %0d locators checked.",
                 words_sent, book.checked);
        $display("Summary: level counts 0 to 7, span edges, saturation and cell boundaries.");
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
